>>> hdl/assert_macros.svh
// assertion helpers shared by the foot sum, height divider and top modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, held off while reset is asserted
`define ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, held off while reset is asserted
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hdl/slbh_pkg.sv
package slbh_pkg;

  // leg count and field widths
  localparam int NUM_LEGS    = 4;
  localparam int MAX_LEGS    = 6;
  localparam int Q_W         = 16;
  localparam int COORD_W     = 16;
  localparam int FOOT_W      = 3 * COORD_W;
  localparam int QUAT_BITS   = 4 * Q_W;
  localparam int CFG_W       = 15;
  localparam int OUT_W       = 16;
  localparam int IN_BITS     = QUAT_BITS + NUM_LEGS * FOOT_W + NUM_LEGS;
  localparam int IN_TDATA_W  = ((IN_BITS + 7) / 8) * 8;

  // datapath widths
  localparam int PROD_W      = 2 * Q_W;
  localparam int R_W         = PROD_W + 2;
  localparam int LP_W        = R_W + COORD_W;
  localparam int FZ_W        = LP_W + 2;
  localparam int CNT_W       = $clog2(NUM_LEGS + 1);
  localparam int SUM_W       = FZ_W + $clog2(NUM_LEGS);
  localparam int FRAC_SH     = 28;
  localparam int A_W         = SUM_W + 1;
  localparam int TF_W        = A_W - FRAC_SH;
  localparam int OUT_MAX     = 32767;
  localparam int OUT_MIN_MAG = 32768;
  localparam int T_CLAMP     = NUM_LEGS * (OUT_MIN_MAG + 1);
  localparam int T_W         = $clog2(T_CLAMP + 1);
  localparam int M_W         = T_W + 1;
  localparam int ONE_Q28     = 1 << FRAC_SH;
  localparam int FALLBACK_RST = 1229;

  // reciprocal table, floor(2^T_W / count)
  localparam int RECIP_IDX_W = $clog2(MAX_LEGS + 1);
  typedef logic [M_W-1:0] recip_t;
  localparam recip_t RECIP [0:MAX_LEGS] = '{
    recip_t'(0),
    recip_t'((1 << T_W) / 1),
    recip_t'((1 << T_W) / 2),
    recip_t'((1 << T_W) / 3),
    recip_t'((1 << T_W) / 4),
    recip_t'((1 << T_W) / 5),
    recip_t'((1 << T_W) / 6)
  };

  typedef logic signed [Q_W-1:0] quat_part_t;
  typedef logic [FOOT_W-1:0] foot_t;

  typedef struct packed {
    quat_part_t w;
    quat_part_t x;
    quat_part_t y;
    quat_part_t z;
  } quat_t;

  // one input item, unpacked
  typedef struct packed {
    quat_t                      quat;
    foot_t [NUM_LEGS-1:0]       feet;
    logic  [NUM_LEGS-1:0]       mask;
  } item_t;

  // third rotation row with the foot data
  typedef struct packed {
    logic signed [R_W-1:0]      r31;
    logic signed [R_W-1:0]      r32;
    logic signed [R_W-1:0]      r33;
    foot_t [NUM_LEGS-1:0]       feet;
    logic  [NUM_LEGS-1:0]       mask;
  } rot_t;

  // summed world z over legs in contact
  typedef struct packed {
    logic signed [SUM_W-1:0]    sum;
    logic [CNT_W-1:0]           cnt;
  } sum_t;

endpackage

>>> hdl/slbh_rot_row.sv
module slbh_rot_row import slbh_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_valid,
  output logic  in_ready,
  input  item_t in_item,
  output logic  out_valid,
  input  logic  out_ready,
  output rot_t  out_rot
);

  logic rdy1, rdy2;
  logic v1_r, v2_r;
  logic signed [PROD_W-1:0] xz_r, wy_r, yz_r, wx_r, xx_r, yy_r;
  foot_t [NUM_LEGS-1:0] feet1_r;
  logic [NUM_LEGS-1:0] mask1_r;
  rot_t rot_nxt, rot2_r;

  // stage ready chain
  assign rdy2     = !v2_r || out_ready;
  assign rdy1     = !v1_r || rdy2;
  assign in_ready = rdy1;

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      if (rdy1) v1_r <= in_valid;
      if (rdy2) v2_r <= v1_r;
    end
  end

  // stage 1: quaternion products
  always_ff @(posedge clk) begin
    if (rdy1 && in_valid) begin
      xz_r    <= in_item.quat.x * in_item.quat.z;
      wy_r    <= in_item.quat.w * in_item.quat.y;
      yz_r    <= in_item.quat.y * in_item.quat.z;
      wx_r    <= in_item.quat.w * in_item.quat.x;
      xx_r    <= in_item.quat.x * in_item.quat.x;
      yy_r    <= in_item.quat.y * in_item.quat.y;
      feet1_r <= in_item.feet;
      mask1_r <= in_item.mask;
    end
  end

  // stage 2: third row of the rotation matrix, Q.28
  always_comb begin
    rot_nxt.r31  = (R_W'(xz_r) - R_W'(wy_r)) <<< 1;
    rot_nxt.r32  = (R_W'(yz_r) + R_W'(wx_r)) <<< 1;
    rot_nxt.r33  = R_W'(ONE_Q28) - (R_W'(xx_r) <<< 1) - (R_W'(yy_r) <<< 1);
    rot_nxt.feet = feet1_r;
    rot_nxt.mask = mask1_r;
  end

  always_ff @(posedge clk) begin
    if (rdy2 && v1_r) begin
      rot2_r <= rot_nxt;
    end
  end

  assign out_valid = v2_r;
  assign out_rot   = rot2_r;

endmodule

>>> hdl/slbh_foot_sum.sv
`include "assert_macros.svh"

module slbh_foot_sum import slbh_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  rot_t in_rot,
  output logic out_valid,
  input  logic out_ready,
  output sum_t out_sum
);

  logic rdy3, rdy4, rdy5;
  logic v3_r, v4_r, v5_r;
  logic signed [LP_W-1:0] lpx_nxt [NUM_LEGS];
  logic signed [LP_W-1:0] lpy_nxt [NUM_LEGS];
  logic signed [LP_W-1:0] lpz_nxt [NUM_LEGS];
  logic signed [LP_W-1:0] lpx_r [NUM_LEGS];
  logic signed [LP_W-1:0] lpy_r [NUM_LEGS];
  logic signed [LP_W-1:0] lpz_r [NUM_LEGS];
  logic signed [COORD_W-1:0] px [NUM_LEGS];
  logic signed [COORD_W-1:0] py [NUM_LEGS];
  logic signed [COORD_W-1:0] pz [NUM_LEGS];
  logic [NUM_LEGS-1:0] mask3_r, mask4_r;
  logic signed [FZ_W-1:0] fz_nxt [NUM_LEGS];
  logic signed [FZ_W-1:0] fz4_r [NUM_LEGS];
  sum_t sum_nxt, sum5_r;

  // stage ready chain
  assign rdy5     = !v5_r || out_ready;
  assign rdy4     = !v4_r || rdy5;
  assign rdy3     = !v3_r || rdy4;
  assign in_ready = rdy3;

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
    end else begin
      if (rdy3) v3_r <= in_valid;
      if (rdy4) v4_r <= v3_r;
      if (rdy5) v5_r <= v4_r;
    end
  end

  // stage 3: row entry times each foot coordinate
  always_comb begin
    for (int i = 0; i < NUM_LEGS; i++) begin
      px[i]      = in_rot.feet[i][0*COORD_W +: COORD_W];
      py[i]      = in_rot.feet[i][1*COORD_W +: COORD_W];
      pz[i]      = in_rot.feet[i][2*COORD_W +: COORD_W];
      lpx_nxt[i] = in_rot.r31 * px[i];
      lpy_nxt[i] = in_rot.r32 * py[i];
      lpz_nxt[i] = in_rot.r33 * pz[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rdy3 && in_valid) begin
      lpx_r   <= lpx_nxt;
      lpy_r   <= lpy_nxt;
      lpz_r   <= lpz_nxt;
      mask3_r <= in_rot.mask;
    end
  end

  // stage 4: world z per foot, zero for legs in swing
  always_comb begin
    for (int i = 0; i < NUM_LEGS; i++) begin
      if (mask3_r[i]) begin
        fz_nxt[i] = FZ_W'(lpx_r[i]) + FZ_W'(lpy_r[i]) + FZ_W'(lpz_r[i]);
      end else begin
        fz_nxt[i] = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy4 && v3_r) begin
      fz4_r   <= fz_nxt;
      mask4_r <= mask3_r;
    end
  end

  // stage 5: sum over legs and contact count
  always_comb begin
    sum_nxt.sum = '0;
    for (int i = 0; i < NUM_LEGS; i++) begin
      sum_nxt.sum = sum_nxt.sum + SUM_W'(fz4_r[i]);
    end
    sum_nxt.cnt = CNT_W'($countones(mask4_r));
  end

  always_ff @(posedge clk) begin
    if (rdy5 && v4_r) begin
      sum5_r <= sum_nxt;
    end
  end

  assign out_valid = v5_r;
  assign out_sum   = sum5_r;

  // no leg in contact leaves nothing in the sum
  `ASSERT_IMPL(a_no_contact_zero_sum, v5_r && (sum5_r.cnt == '0), sum5_r.sum == '0, "sum without contact")

endmodule

>>> hdl/slbh_height_div.sv
`include "assert_macros.svh"

module slbh_height_div import slbh_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic [CFG_W-1:0]        fallback,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  sum_t                    in_sum,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic signed [OUT_W-1:0] out_height,
  output logic                    out_fb
);

  localparam logic signed [OUT_W-1:0] H_MIN = {1'b1, {(OUT_W-1){1'b0}}};
  localparam logic signed [OUT_W-1:0] H_MAX = OUT_W'(OUT_MAX);

  logic rdy6, rdy7, rdy8, rdy9;
  logic v6_r, v7_r, v8_r, v9_r;
  logic [SUM_W-1:0] mag_nxt, mag6_r;
  logic neg_nxt, neg6_r, neg7_r, neg8_r;
  logic [CNT_W-1:0] cnt6_r, cnt7_r, cnt8_r;
  logic [A_W-1:0] rnd_sum;
  logic [TF_W-1:0] t_full;
  logic [T_W-1:0] t_nxt, t7_r, t8_r;
  logic [T_W+M_W-1:0] q_prod;
  logic [T_W-1:0] q0_nxt, q8_r;
  logic [T_W-1:0] rem;
  logic [T_W-1:0] q_fix;
  logic signed [OUT_W-1:0] height_nxt, height9_r;
  logic fb_nxt, fb9_r;

  // stage ready chain
  assign rdy9     = !v9_r || out_ready;
  assign rdy8     = !v8_r || rdy9;
  assign rdy7     = !v7_r || rdy8;
  assign rdy6     = !v6_r || rdy7;
  assign in_ready = rdy6;

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v6_r <= 1'b0;
      v7_r <= 1'b0;
      v8_r <= 1'b0;
      v9_r <= 1'b0;
    end else begin
      if (rdy6) v6_r <= in_valid;
      if (rdy7) v7_r <= v6_r;
      if (rdy8) v8_r <= v7_r;
      if (rdy9) v9_r <= v8_r;
    end
  end

  // stage 6: magnitude of the negated sum
  always_comb begin
    if (in_sum.sum[SUM_W-1]) begin
      mag_nxt = SUM_W'(-in_sum.sum);
    end else begin
      mag_nxt = SUM_W'(in_sum.sum);
    end
    neg_nxt = !in_sum.sum[SUM_W-1] && (in_sum.sum != '0);
  end

  always_ff @(posedge clk) begin
    if (rdy6 && in_valid) begin
      mag6_r <= mag_nxt;
      neg6_r <= neg_nxt;
      cnt6_r <= in_sum.cnt;
    end
  end

  // stage 7: add half a step, drop the fraction, clamp far outside the range
  always_comb begin
    rnd_sum = A_W'(mag6_r) + (A_W'(cnt6_r) << (FRAC_SH - 1));
    t_full  = TF_W'(rnd_sum >> FRAC_SH);
    if (t_full > TF_W'(T_CLAMP)) begin
      t_nxt = T_W'(T_CLAMP);
    end else begin
      t_nxt = t_full[T_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rdy7 && v6_r) begin
      t7_r   <= t_nxt;
      neg7_r <= neg6_r;
      cnt7_r <= cnt6_r;
    end
  end

  // stage 8: quotient estimate by reciprocal, low by at most one
  always_comb begin
    q_prod = t7_r * RECIP[RECIP_IDX_W'(cnt7_r)];
    q0_nxt = T_W'(q_prod >> T_W);
  end

  always_ff @(posedge clk) begin
    if (rdy8 && v7_r) begin
      q8_r   <= q0_nxt;
      t8_r   <= t7_r;
      neg8_r <= neg7_r;
      cnt8_r <= cnt7_r;
    end
  end

  // stage 9: quotient fix-up, sign, saturation and fallback
  always_comb begin
    rem   = t8_r - T_W'(cnt8_r * q8_r);
    q_fix = q8_r + T_W'(rem >= T_W'(cnt8_r));
    fb_nxt = (cnt8_r == '0);
    if (fb_nxt) begin
      height_nxt = OUT_W'(fallback);
    end else if (neg8_r) begin
      if (q_fix > T_W'(OUT_MIN_MAG)) begin
        height_nxt = H_MIN;
      end else begin
        height_nxt = -OUT_W'(q_fix);
      end
    end else begin
      if (q_fix > T_W'(OUT_MAX)) begin
        height_nxt = H_MAX;
      end else begin
        height_nxt = OUT_W'(q_fix);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy9 && v8_r) begin
      height9_r <= height_nxt;
      fb9_r     <= fb_nxt;
    end
  end

  assign out_valid  = v9_r;
  assign out_height = height9_r;
  assign out_fb     = fb9_r;

  // reciprocal estimate never off by more than one step
  `ASSERT_IMPL(a_quot_estimate, v8_r && (cnt8_r != '0), (t8_r - T_W'(cnt8_r * q8_r)) < (T_W'(cnt8_r) << 1), "quotient estimate off")

  // an item without contact comes out flagged with the fallback height
  `ASSERT_NEXT(a_fallback_out, v8_r && rdy9 && (cnt8_r == '0), out_valid && out_fb && (out_height == OUT_W'(fallback)), "fallback item wrong")

endmodule

>>> hdl/stance_leg_body_height.sv
// Kinematic body-height estimate for a legged robot.
// in_*: one item per handshake carrying the orientation quaternion, the
//   body-frame foot positions and the contact mask (see in_tdata comment).
// out_*: one result item per input item, in order: the height (Q4.12,
//   rounded to nearest, saturated) and a flag set when no leg was in contact
//   and the configured fallback height was returned.
// cfg_*: write of the 15-bit fallback height, always ready; write it only
//   while no item is in flight.
// Throughput: one item per clock cycle while out_tready is high. Pipeline: nine
//   register stages: quaternion products, rotation row, foot products, foot z,
//   leg sum, magnitude, rounding shift, reciprocal multiply and the final
//   fix-up with saturation.
// Reset: all stage valid bits clear, fallback height returns to 1229.
// Stall: each stage holds while its successor is full and stalled; in_tready
//   drops only once every stage holds an item and out_tready is low. Nothing is
//   dropped or repeated.
`include "assert_macros.svh"

module stance_leg_body_height import slbh_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  // quat_w, quat_x, quat_y, quat_z, foot0_pos .. foot3_pos, contact_mask
  input  logic [IN_TDATA_W-1:0] in_tdata,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // body_height
  output logic [OUT_W-1:0]      out_tdata,
  // used_fallback
  output logic [0:0]            out_tuser,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_W-1:0]      cfg_data
);

  logic [CFG_W-1:0] fallback_r;
  item_t in_item;
  rot_t  rot;
  sum_t  leg_sum;
  logic  rot_valid, rot_ready;
  logic  sum_valid, sum_ready;
  logic signed [OUT_W-1:0] height;
  logic  fb;

  // fallback height register
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fallback_r <= CFG_W'(FALLBACK_RST);
    end else if (cfg_valid) begin
      fallback_r <= cfg_data;
    end
  end

  // unpack the input item
  always_comb begin
    in_item.quat.w = in_tdata[0*Q_W +: Q_W];
    in_item.quat.x = in_tdata[1*Q_W +: Q_W];
    in_item.quat.y = in_tdata[2*Q_W +: Q_W];
    in_item.quat.z = in_tdata[3*Q_W +: Q_W];
    for (int i = 0; i < NUM_LEGS; i++) begin
      in_item.feet[i] = in_tdata[QUAT_BITS + i*FOOT_W +: FOOT_W];
    end
    in_item.mask = in_tdata[QUAT_BITS + NUM_LEGS*FOOT_W +: NUM_LEGS];
  end

  slbh_rot_row u_rot_row (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_item   (in_item),
    .out_valid (rot_valid),
    .out_ready (rot_ready),
    .out_rot   (rot)
  );

  slbh_foot_sum u_foot_sum (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (rot_valid),
    .in_ready  (rot_ready),
    .in_rot    (rot),
    .out_valid (sum_valid),
    .out_ready (sum_ready),
    .out_sum   (leg_sum)
  );

  slbh_height_div u_height_div (
    .clk        (clk),
    .rst_n      (rst_n),
    .fallback   (fallback_r),
    .in_valid   (sum_valid),
    .in_ready   (sum_ready),
    .in_sum     (leg_sum),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_height (height),
    .out_fb     (fb)
  );

  assign out_tdata = height;
  assign out_tuser = fb;

  // input back-pressure only when the whole pipe is full and stalled
  `ASSERT_IMPL(a_backpressure, !in_tready, out_tvalid && !out_tready, "input stalled with room in the pipe")

endmodule
